@@ design/amb_pkg.sv @@
// Shared types, opcodes and cipher constants for the ARX-and-multiply block cipher.
// No dependencies; every other design file imports this package.
`default_nettype none

package amb_pkg;

	localparam int AMB_ROUNDS = 8;
	localparam int KEY_DEPTH  = 16;
	localparam int KEY_IDX_W  = $clog2(KEY_DEPTH);

	typedef enum logic [1:0] {
		OP_ENC  = 2'd0,
		OP_DEC  = 2'd1,
		OP_LOAD = 2'd2,
		OP_NONE = 2'd3
	} amb_op_t;

	// Four 32-bit words; word 0 sits in the lowest bits.
	typedef logic [3:0][31:0] amb_blk_t;

	typedef struct packed {
		logic valid;
		logic dec;
	} amb_ctl_t;

	localparam amb_blk_t FWD_MUL = {32'hf9c1e3c7, 32'h172f4f2f, 32'h47dff15d, 32'h71e961dd};
	localparam amb_blk_t BACK_MUL = {32'h4d82edf7, 32'hfb0a57cf, 32'h185beaf5, 32'hf6e1fe75};

	localparam int ROT0 = 13;
	localparam int ROT1 = 7;
	localparam int ROT2 = 11;
	localparam int ROT3 = 15;

	function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

endpackage

`default_nettype wire

@@ design/amb_round.sv @@
// One cipher round as three pipeline stages, serving both encrypt and decrypt.
// Depends on amb_pkg for the block type, control struct and constants.
`default_nettype none

module amb_round (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire amb_pkg::amb_ctl_t ctl_i,
	input  wire amb_pkg::amb_blk_t blk_i,
	input  wire amb_pkg::amb_blk_t key_enc,
	input  wire amb_pkg::amb_blk_t key_dec,
	output amb_pkg::amb_ctl_t      ctl_o,
	output amb_pkg::amb_blk_t      blk_o,
	output logic                   busy
);
	import amb_pkg::*;

	amb_ctl_t ctl_s1, ctl_s2, ctl_s3;
	amb_blk_t blk_s1, blk_s2, blk_s3;
	amb_blk_t nxt1, nxt2, nxt3;
	logic [31:0] sum23, sum01, sum30;

	// Encrypt: first half of the chained mix. Decrypt: key XOR and inverse multiply.
	always_comb begin
		nxt1  = blk_i;
		sum23 = blk_i[2] + blk_i[3];
		if (ctl_i.dec) begin
			for (int i = 0; i < 4; i++) begin
				nxt1[i] = (blk_i[i] ^ key_dec[i]) * BACK_MUL[i];
			end
		end else begin
			nxt1[0] = rotl(blk_i[0], ROT0) + blk_i[1] + sum23;
			nxt1[1] = rotl(blk_i[1], ROT1) + sum23 + nxt1[0];
		end
	end

	// Encrypt: second half of the mix. Decrypt: undo the mix of words 3 and 2.
	always_comb begin
		nxt2  = blk_s1;
		sum01 = blk_s1[0] + blk_s1[1];
		if (ctl_s1.dec) begin
			nxt2[3] = rotr(blk_s1[3] - sum01 - blk_s1[2], ROT3);
			nxt2[2] = rotr(blk_s1[2] - nxt2[3] - sum01, ROT2);
		end else begin
			nxt2[2] = rotl(blk_s1[2], ROT2) + blk_s1[3] + sum01;
			nxt2[3] = rotl(blk_s1[3], ROT3) + sum01 + nxt2[2];
		end
	end

	// Encrypt: multiply and key XOR. Decrypt: undo the mix of words 1 and 0.
	always_comb begin
		nxt3  = blk_s2;
		sum30 = blk_s2[2] + blk_s2[3];
		if (ctl_s2.dec) begin
			nxt3[1] = rotr(blk_s2[1] - sum30 - blk_s2[0], ROT1);
			nxt3[0] = rotr(blk_s2[0] - nxt3[1] - sum30, ROT0);
		end else begin
			for (int i = 0; i < 4; i++) begin
				nxt3[i] = (blk_s2[i] * FWD_MUL[i]) ^ key_enc[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_i;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			blk_s1 <= nxt1;
			blk_s2 <= nxt2;
			blk_s3 <= nxt3;
		end
	end

	assign ctl_o = ctl_s3;
	assign blk_o = blk_s3;
	assign busy  = ctl_s1.valid | ctl_s2.valid | ctl_s3.valid;

endmodule

`default_nettype wire

@@ design/arx_multiply_block_cipher.sv @@
// Top level of the ARX-and-multiply block cipher: key store and round pipeline.
// Depends on amb_pkg and amb_round.
//
// The cipher takes one 128-bit block per cycle while no result is stalled and
// returns it through the round pipeline; every round is three register stages
// (mix, mix, multiply for encryption; multiply, unmix, unmix for decryption),
// so encrypt and decrypt beats may be freely interleaved. The whole pipeline
// advances together: while a result waits on m_tready, no new beat is taken.
// A round key load (opcode 2) is taken only once the pipeline is empty, so a
// load waits until any blocks in flight have drained out of the pipeline;
// blocks sent after the load use the new key. Loads and opcode 3 give no result.
// Key entries must be loaded before any block that uses them.
`default_nettype none

module arx_multiply_block_cipher #(
	parameter int ROUNDS = amb_pkg::AMB_ROUNDS
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// [3:0] key_word_index, [67:4] data_low, [131:68] data_high, [135:132] zero
	input  wire logic [135:0] s_tdata,
	// [1:0] opcode
	input  wire logic [1:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// [63:0] result_low, [127:64] result_high
	output logic [127:0]      m_tdata
);
	import amb_pkg::*;

	logic [63:0] key_q [KEY_DEPTH];

	amb_ctl_t          ctl_c [ROUNDS+1];
	amb_blk_t          blk_c [ROUNDS+1];
	logic [ROUNDS-1:0] busy_c;
	logic              en;
	logic              busy;
	logic              accept;
	amb_op_t           op;

	assign op     = amb_op_t'(s_tuser);
	assign en     = !m_tvalid || m_tready;
	assign busy   = |busy_c;
	assign s_tready = en && ((op != OP_LOAD) || !busy);
	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk) begin
		if (accept && (op == OP_LOAD)) begin
			key_q[s_tdata[KEY_IDX_W-1:0]] <= s_tdata[67:4];
		end
	end

	assign ctl_c[0].valid = accept && ((op == OP_ENC) || (op == OP_DEC));
	assign ctl_c[0].dec   = (op == OP_DEC);
	assign blk_c[0]       = s_tdata[131:4];

	for (genvar j = 0; j < ROUNDS; j++) begin : g_round
		// Encryption runs rounds upward, decryption downward through the same slots.
		localparam int ER = j;
		localparam int DR = ROUNDS - 1 - j;
		localparam logic [KEY_IDX_W-1:0] E_LO = KEY_IDX_W'((2 * ER) % KEY_DEPTH);
		localparam logic [KEY_IDX_W-1:0] E_HI = KEY_IDX_W'((2 * ER + 1) % KEY_DEPTH);
		localparam logic [KEY_IDX_W-1:0] D_LO = KEY_IDX_W'((2 * DR) % KEY_DEPTH);
		localparam logic [KEY_IDX_W-1:0] D_HI = KEY_IDX_W'((2 * DR + 1) % KEY_DEPTH);

		amb_blk_t key_enc, key_dec;

		assign key_enc = {key_q[E_HI], key_q[E_LO]};
		assign key_dec = {key_q[D_HI], key_q[D_LO]};

		amb_round u_round (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.ctl_i   (ctl_c[j]),
			.blk_i   (blk_c[j]),
			.key_enc (key_enc),
			.key_dec (key_dec),
			.ctl_o   (ctl_c[j+1]),
			.blk_o   (blk_c[j+1]),
			.busy    (busy_c[j])
		);
	end

	assign m_tvalid = ctl_c[ROUNDS].valid;
	assign m_tdata  = blk_c[ROUNDS];

endmodule

`default_nettype wire

@@ design/amb_checker.sv @@
// Port-level checks for the ARX-and-multiply block cipher, bound to its top level.
// Depends on amb_pkg and arx_multiply_block_cipher.
`default_nettype none

module amb_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_tvalid,
	input wire logic         s_tready,
	input wire logic [1:0]   s_tuser,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [127:0] m_tdata
);
	import amb_pkg::*;

	// A result beat that is not taken stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// A key load is taken only with no block in flight, so no result can be pending.
	a_load_drained: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == OP_LOAD) |-> !m_tvalid)
		else $error("key load taken while blocks were in flight");

	// The pipeline advances as a whole: a stalled result blocks the input.
	a_stall_input: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while output was stalled");

	// The pipeline is empty coming out of reset, so no result shows in the next cycle.
	a_no_result_after_reset: assert property (@(posedge clk)
		!arst_n |=> !m_tvalid)
		else $error("result shown right after reset");

endmodule

bind arx_multiply_block_cipher amb_checker u_amb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
